// ===== rtl/core/bssc_pkg.sv =====
// Shared types and constants for the block statistics surface classifier.
// No dependencies; every other file in rtl/core refers to this package by scope.
package bssc_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int SQUARE_W      = 31;   // |sample|^2 <= 2^30
	localparam int BLOCK_LEN_DEF = 8;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic [1:0] {
		STATUS_UNDET = 2'd0,
		STATUS_HIGH  = 2'd1,
		STATUS_LOW   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CLS_NEAR = 2'd0,
		CLS_MID  = 2'd1,
		CLS_FAR  = 2'd2
	} sample_cls_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEVEL_THRESHOLD = 3'd0,
		REG_NEAR_BOUND      = 3'd1,
		REG_FAR_BOUND       = 3'd2,
		REG_LOW_MARGIN      = 3'd3,
		REG_SPREAD_LIMIT    = 3'd4,
		REG_FAR_COUNT_MIN   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] level_threshold;
		logic signed [15:0] near_bound;
		logic signed [15:0] far_bound;
		logic [14:0]        low_margin;
		logic [15:0]        spread_limit;
		logic [6:0]         far_count_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		level_threshold: 16'sd1500,
		near_bound:      16'sd1200,
		far_bound:       16'sd2000,
		low_margin:      15'd400,
		spread_limit:    16'd500,
		far_count_min:   7'd2
	};

	// One classified sample travelling from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [SQUARE_W-1:0]        square;
		sample_cls_t                cls;
		logic                       seed_high;
	} item_t;

endpackage

// ===== rtl/core/bssc_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Payload widths come from bssc_pkg.
interface bssc_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bssc_pkg::SAMPLE_W-1:0]  sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface bssc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       block_done;

	modport source(output valid, output status, output block_done, input ready);
	modport sink(input valid, input status, input block_done, output ready);
endinterface

// ===== rtl/core/block_stats_surface_classifier.sv =====
// Top level of the block statistics surface classifier: configuration registers,
// front, queue and back. Uses bssc_pkg, bssc_if, bssc_front, bssc_queue, bssc_back.
//
//   channel   dir  handshake              beat payload
//   samples   in   valid/ready            sample (16b signed)
//   results   out  valid/ready            status (2b), block_done (1b)
//   cfg       in   cfg_wr_en, no ready    cfg_index (3b), cfg_data (16b)
//
// One sample beat per cycle sustained while results are taken, one result beat per sample, in order.
// The path from accept to result runs through the front register, queue, accumulate,
// multiply, compare and multiply stages and the output register.
// Stalls on results freeze the back pipeline; the four-entry queue and the front
// register keep taking samples until they fill.
// Reset is asynchronous; configuration registers come up at their CFG_RESET defaults.
module block_stats_surface_classifier #(
	parameter int BLOCK_LEN = bssc_pkg::BLOCK_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bssc_sample_if.sink                         samples,
	bssc_result_if.source                       results,
	input  logic                                cfg_wr_en,
	input  logic [bssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bssc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	bssc_pkg::cfg_t   cfg_q;
	bssc_pkg::item_t  front_item, queue_item;
	logic             front_valid, front_ready;
	logic             queue_valid, queue_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bssc_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (bssc_pkg::reg_idx_t'(cfg_index))
				bssc_pkg::REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data;
				bssc_pkg::REG_NEAR_BOUND:      cfg_q.near_bound      <= cfg_data;
				bssc_pkg::REG_FAR_BOUND:       cfg_q.far_bound       <= cfg_data;
				bssc_pkg::REG_LOW_MARGIN:      cfg_q.low_margin      <= cfg_data[14:0];
				bssc_pkg::REG_SPREAD_LIMIT:    cfg_q.spread_limit    <= cfg_data;
				bssc_pkg::REG_FAR_COUNT_MIN:   cfg_q.far_count_min   <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	bssc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.samples    (samples),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	bssc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (queue_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	bssc_back #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (queue_item),
		.item_valid (queue_valid),
		.item_ready (queue_ready),
		.results    (results)
	);

endmodule

// ===== rtl/core/bssc_front.sv =====
// Front end: takes sample beats, squares and bins each sample, seeds the status compare.
// Uses bssc_pkg and bssc_sample_if.
module bssc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bssc_pkg::cfg_t       cfg,
	bssc_sample_if.sink          samples,
	output bssc_pkg::item_t      item,
	output logic                 item_valid,
	input  logic                 item_ready
);

	logic                   valid_q;
	bssc_pkg::item_t        item_q;
	bssc_pkg::item_t        item_d;
	logic signed [31:0]     prod;
	logic                   accept;

	assign samples.ready = !valid_q || item_ready;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		prod             = samples.sample * samples.sample;
		item_d.sample    = samples.sample;
		item_d.square    = prod[bssc_pkg::SQUARE_W-1:0];
		item_d.seed_high = samples.sample >= cfg.level_threshold;
		// near wins over mid, mid over far, even when the bounds cross
		priority if (samples.sample < cfg.near_bound) begin
			item_d.cls = bssc_pkg::CLS_NEAR;
		end else if (samples.sample < cfg.far_bound) begin
			item_d.cls = bssc_pkg::CLS_MID;
		end else begin
			item_d.cls = bssc_pkg::CLS_FAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (samples.ready) begin
			valid_q <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_d;
		end
	end

	assign item       = item_q;
	assign item_valid = valid_q;

endmodule

// ===== rtl/core/bssc_queue.sv =====
// Short FIFO of classified samples between front and back.
// Uses bssc_pkg (item_t, QUEUE_DEPTH).
module bssc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  bssc_pkg::item_t  push_item,
	input  logic             push_valid,
	output logic             push_ready,
	output bssc_pkg::item_t  pop_item,
	output logic             pop_valid,
	input  logic             pop_ready
);

	localparam int DEPTH = bssc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bssc_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

// ===== rtl/core/bssc_back.sv =====
// Back end: block accumulators, three-stage block statistics pipeline, status state,
// output register. Uses bssc_pkg and bssc_result_if.
module bssc_back #(
	parameter int BLOCK_LEN = bssc_pkg::BLOCK_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bssc_pkg::cfg_t   cfg,
	input  bssc_pkg::item_t  item,
	input  logic             item_valid,
	output logic             item_ready,
	bssc_result_if.source    results
);

	localparam int LOG_N  = $clog2(BLOCK_LEN);
	localparam int FILL_W = LOG_N;
	localparam int CNT_W  = $clog2(BLOCK_LEN + 1);
	localparam int SUM_W  = bssc_pkg::SAMPLE_W + LOG_N;
	localparam int SQ_W   = bssc_pkg::SQUARE_W + LOG_N;
	localparam int SPR_W  = 2 * SUM_W + 2;
	localparam int THR_W  = SUM_W + 4;
	localparam int WSQ_W  = 34;
	localparam logic [FILL_W-1:0]       FILL_LAST = FILL_W'(BLOCK_LEN - 1);
	localparam logic signed [THR_W-1:0] N_THR     = THR_W'(BLOCK_LEN);
	localparam logic [SPR_W-1:0]        N_SPR     = SPR_W'(BLOCK_LEN);
	localparam logic [SPR_W-1:0]        NN_SPR    = SPR_W'(BLOCK_LEN * BLOCK_LEN);

	logic en;
	logic pop;

	// accumulators
	logic [FILL_W-1:0]       fill_q;
	logic signed [SUM_W-1:0] sum_acc_q;
	logic [SQ_W-1:0]         sq_acc_q;
	logic [CNT_W-1:0]        mid_acc_q;
	logic [CNT_W-1:0]        far_acc_q;
	logic signed [SUM_W-1:0] sum_next;
	logic [SQ_W-1:0]         sq_next;
	logic [CNT_W-1:0]        mid_next;
	logic [CNT_W-1:0]        far_next;
	logic                    last;

	// stage 1: block totals
	logic                    valid_s1, last_s1, seed_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic [SQ_W-1:0]         sq_s1;
	logic [CNT_W-1:0]        mid_s1, far_s1;

	// stage 2: products
	logic                      valid_s2, last_s2, seed_s2, quiet_s2, far_ok_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [2*SUM_W-1:0] sum_prod;
	logic [SPR_W-1:0]          sumsq_s2, nsq_s2;
	logic [WSQ_W-1:0]          wsq_s2;
	logic signed [THR_W-1:0]   nt_s2, nl_s2;
	logic [16:0]               spread_w;
	logic signed [17:0]        low_lvl;
	logic signed [THR_W-1:0]   sum_x;

	// stage 3: compares and spread terms
	logic             valid_s3, last_s3, seed_s3, quiet_s3, far_ok_s3;
	logic             hi_lvl_s3, lo_lvl_s3;
	logic [SPR_W-1:0] lhs_s3, rhs_s3;

	// status state and output register
	bssc_pkg::status_t cur_q;
	logic              pend_q;
	bssc_pkg::status_t base_status, status_next;
	logic              pend_next;
	logic              spread_ok;
	logic              res_valid_q;
	bssc_pkg::status_t status_q;
	logic              done_q;

	assign en         = !res_valid_q || results.ready;
	assign item_ready = en;
	assign pop        = en && item_valid;

	always_comb begin
		sum_next = sum_acc_q + SUM_W'(item.sample);
		sq_next  = sq_acc_q + SQ_W'(item.square);
		mid_next = mid_acc_q + CNT_W'(item.cls == bssc_pkg::CLS_MID);
		far_next = far_acc_q + CNT_W'(item.cls == bssc_pkg::CLS_FAR);
		last     = fill_q == FILL_LAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			sum_acc_q <= '0;
			sq_acc_q  <= '0;
			mid_acc_q <= '0;
			far_acc_q <= '0;
		end else if (pop) begin
			if (last) begin
				fill_q    <= '0;
				sum_acc_q <= '0;
				sq_acc_q  <= '0;
				mid_acc_q <= '0;
				far_acc_q <= '0;
			end else begin
				fill_q    <= fill_q + 1'b1;
				sum_acc_q <= sum_next;
				sq_acc_q  <= sq_next;
				mid_acc_q <= mid_next;
				far_acc_q <= far_next;
			end
		end
	end

	always_comb begin
		sum_prod = sum_s1 * sum_s1;
		spread_w = {cfg.spread_limit, 1'b1};
		low_lvl  = 18'(cfg.level_threshold) - {3'b000, cfg.low_margin};
		sum_x    = THR_W'(sum_s2);
		spread_ok = lhs_s3 < rhs_s3;
	end

	// pipeline valid bits; the whole back end moves on en
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last;
			seed_s1 <= item.seed_high;
			sum_s1  <= sum_next;
			sq_s1   <= sq_next;
			mid_s1  <= mid_next;
			far_s1  <= far_next;

			last_s2   <= last_s1;
			seed_s2   <= seed_s1;
			sum_s2    <= sum_s1;
			quiet_s2  <= (mid_s1 == '0) && (far_s1 == '0);
			far_ok_s2 <= 7'(far_s1) >= cfg.far_count_min;
			sumsq_s2  <= SPR_W'($unsigned(sum_prod));
			nsq_s2    <= N_SPR * SPR_W'(sq_s1);
			wsq_s2    <= spread_w * spread_w;
			nt_s2     <= N_THR * THR_W'(cfg.level_threshold);
			nl_s2     <= N_THR * THR_W'(low_lvl);

			last_s3   <= last_s2;
			seed_s3   <= seed_s2;
			quiet_s3  <= quiet_s2;
			far_ok_s3 <= far_ok_s2;
			// average truncates toward zero: floor for positive sums, ceiling for negative
			hi_lvl_s3 <= (sum_s2 >= 0) ? (sum_x >= nt_s2 + N_THR) : (sum_x > nt_s2);
			lo_lvl_s3 <= (sum_s2 >= 0) ? (sum_x < nl_s2) : (sum_x <= nl_s2 - N_THR);
			lhs_s3    <= (nsq_s2 - sumsq_s2) << 2;
			rhs_s3    <= SPR_W'(wsq_s2) * NN_SPR;

			status_q <= status_next;
			done_q   <= last_s3;
		end
	end

	always_comb begin
		base_status = cur_q;
		if (cur_q == bssc_pkg::STATUS_UNDET) begin
			base_status = seed_s3 ? bssc_pkg::STATUS_HIGH : bssc_pkg::STATUS_LOW;
		end
		status_next = base_status;
		pend_next   = pend_q;
		if (last_s3) begin
			priority if (hi_lvl_s3 && far_ok_s3) begin
				status_next = bssc_pkg::STATUS_HIGH;
				pend_next   = 1'b0;
			end else if (lo_lvl_s3 && quiet_s3 && spread_ok) begin
				// second quiet low block in a row switches to low
				if (pend_q) begin
					status_next = bssc_pkg::STATUS_LOW;
				end
				pend_next = 1'b1;
			end else begin
				pend_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= bssc_pkg::STATUS_UNDET;
			pend_q <= 1'b0;
		end else if (en && valid_s3) begin
			cur_q  <= status_next;
			pend_q <= pend_next;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.status     = status_q;
	assign results.block_done = done_q;

	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != bssc_pkg::STATUS_UNDET |=> cur_q != bssc_pkg::STATUS_UNDET)
		else $error("status fell back to undetermined");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_LAST)
		else $error("fill count past block length");

	a_pending_at_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(en && valid_s3 && last_s3))
		else $error("low pending set outside a block end");

	a_result_defined: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.status != bssc_pkg::STATUS_UNDET)
		else $error("result beat with undetermined status");

endmodule

// ===== dv/tb_block_stats_surface_classifier.sv =====
`timescale 1ns / 100ps
// Testbench for block_stats_surface_classifier: directed and random sample beats across
// several register settings, each result checked against an in-bench block statistics model.
// Depends on bssc_pkg, bssc_if and the RTL under rtl/core.
module tb_block_stats_surface_classifier;

	localparam int BLK = bssc_pkg::BLOCK_LEN_DEF;
	localparam int BLOCKS_PER_PHASE = 25;
	localparam int PHASES = 8;

	typedef struct packed {
		bssc_pkg::status_t status;
		logic              block_done;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [bssc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [bssc_pkg::CFG_DATA_W-1:0] cfg_data;

	bssc_sample_if sample_ch();
	bssc_result_if result_ch();

	block_stats_surface_classifier #(.BLOCK_LEN(BLK)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow
	int cfg_thr = 1500;
	int cfg_near = 1200;
	int cfg_far = 2000;
	int cfg_margin = 400;
	int cfg_spread = 500;
	int cfg_far_min = 2;

	// block accumulators and status
	int blk_fill = 0;
	longint acc_sum = 0;
	longint acc_sqsum = 0;
	int mid_seen = 0;
	int far_seen = 0;
	bssc_pkg::status_t cur_status = bssc_pkg::STATUS_UNDET;
	logic low_armed = 1'b0;

	logic signed [15:0] sample_q[$];
	verdict_t verdict_q[$];
	logic sample_taken = 1'b0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int err_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Advance the block statistics by one sample and return the status it yields.
	function automatic verdict_t classify_sample(input logic signed [15:0] s);
		verdict_t v;
		longint smp;
		longint mean;
		longint floor_lvl;
		longint dev;
		longint w;
		smp = s;
		v.block_done = 1'b0;
		if (cur_status == bssc_pkg::STATUS_UNDET)
			cur_status = (smp >= cfg_thr) ? bssc_pkg::STATUS_HIGH : bssc_pkg::STATUS_LOW;
		acc_sum += smp;
		acc_sqsum += smp * smp;
		if (smp >= cfg_near && smp < cfg_far)
			mid_seen++;
		else if (smp >= cfg_near)
			far_seen++;
		blk_fill++;
		if (blk_fill == BLK) begin
			mean = acc_sum / BLK;
			floor_lvl = longint'(cfg_thr) - cfg_margin;
			// rounded std <= limit, squared out: 4*(n*sq - sum^2) < (2L+1)^2 * n^2
			dev = 4 * (BLK * acc_sqsum - acc_sum * acc_sum);
			w = 2 * longint'(cfg_spread) + 1;
			if (mean > cfg_thr && far_seen >= cfg_far_min) begin
				cur_status = bssc_pkg::STATUS_HIGH;
				low_armed = 1'b0;
			end else if (mean < floor_lvl && mid_seen == 0 && far_seen == 0 &&
					dev < w * w * BLK * BLK) begin
				if (low_armed)
					cur_status = bssc_pkg::STATUS_LOW;
				else
					low_armed = 1'b1;
			end else begin
				low_armed = 1'b0;
			end
			blk_fill = 0;
			acc_sum = 0;
			acc_sqsum = 0;
			mid_seen = 0;
			far_seen = 0;
			v.block_done = 1'b1;
		end
		v.status = cur_status;
		return v;
	endfunction

	task automatic write_reg(input bssc_pkg::reg_idx_t idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		case (idx)
			bssc_pkg::REG_LEVEL_THRESHOLD: cfg_thr = value;
			bssc_pkg::REG_NEAR_BOUND:      cfg_near = value;
			bssc_pkg::REG_FAR_BOUND:       cfg_far = value;
			bssc_pkg::REG_LOW_MARGIN:      cfg_margin = value;
			bssc_pkg::REG_SPREAD_LIMIT:    cfg_spread = value;
			bssc_pkg::REG_FAR_COUNT_MIN:   cfg_far_min = value;
			default: ;
		endcase
	endtask

	task automatic apply_config(input int thr, input int near, input int far,
			input int margin, input int spread, input int fmin);
		write_reg(bssc_pkg::REG_LEVEL_THRESHOLD, thr);
		write_reg(bssc_pkg::REG_NEAR_BOUND, near);
		write_reg(bssc_pkg::REG_FAR_BOUND, far);
		write_reg(bssc_pkg::REG_LOW_MARGIN, margin);
		write_reg(bssc_pkg::REG_SPREAD_LIMIT, spread);
		write_reg(bssc_pkg::REG_FAR_COUNT_MIN, fmin);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Queue one block of samples shaped toward a quiet low, a spread edge, a high or noise.
	task automatic gen_block();
		int kind;
		int top;
		int c;
		int d;
		int asym;
		int lo;
		int v;
		kind = $urandom_range(99);
		top = ((cfg_near < cfg_thr - cfg_margin) ? cfg_near : cfg_thr - cfg_margin) - 1;
		if (kind < 55 && top < -32000)
			kind = 99;
		if (kind < 40) begin
			c = clamp16(top - int'($urandom_range(3000)));
			d = $urandom_range(300);
			for (int i = 0; i < BLK; i++)
				sample_q.push_back(16'(clamp16(c - int'($urandom_range(d)))));
		end else if (kind < 55) begin
			// alternating c+d / c-d-asym gives a std of exactly d or d+0.5
			d = cfg_spread + int'($urandom_range(2)) - 1;
			if (d < 0)
				d = 0;
			asym = $urandom_range(1);
			c = top - d - 1 - int'($urandom_range(100));
			for (int i = 0; i < BLK; i++)
				sample_q.push_back(16'(clamp16((i % 2 == 0) ? c + d : c - d - asym)));
		end else if (kind < 80) begin
			lo = (cfg_far > cfg_thr + 1) ? cfg_far : cfg_thr + 1;
			if (lo > 32767)
				lo = 32767;
			d = $urandom_range(100, 40);
			for (int i = 0; i < BLK; i++) begin
				if ($urandom_range(99) < d)
					v = lo + int'($urandom_range(32767 - lo));
				else
					v = int'($urandom_range(65535)) - 32768;
				sample_q.push_back(16'(v));
			end
		end else begin
			for (int i = 0; i < BLK; i++) begin
				case ($urandom_range(21))
					0:  v = cfg_near - 1;
					1:  v = cfg_near;
					2:  v = cfg_far - 1;
					3:  v = cfg_far;
					4:  v = cfg_thr - 1;
					5:  v = cfg_thr;
					6:  v = cfg_thr + 1;
					7:  v = -32768;
					8:  v = 32767;
					9:  v = 0;
					10: v = -1;
					default: v = int'($urandom_range(65535)) - 32768;
				endcase
				sample_q.push_back(16'(clamp16(v)));
			end
		end
	endtask

	task automatic wait_drain();
		do
			@(posedge clk);
		while (sample_q.size() != 0 || sample_ch.valid || verdict_q.size() != 0);
	endtask

	// sample driver and result ready
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_taken) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				sample_ch.valid <= 1'b1;
				sample_ch.sample <= sample_q.pop_front();
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
		result_ch.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	// monitor: check result beats, predict on accepted sample beats
	always @(posedge clk) begin
		verdict_t want;
		sample_taken <= sample_ch.valid && sample_ch.ready;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result beat with none expected: status %0d block_done %0d",
						result_ch.status, result_ch.block_done);
					err_cnt++;
				end else begin
					want = verdict_q.pop_front();
					if (result_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_ch.status);
						err_cnt++;
					end
					if (result_ch.block_done !== want.block_done) begin
						$error("block_done: expected %0d, got %0d", want.block_done,
							result_ch.block_done);
						err_cnt++;
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				verdict_q.push_back(classify_sample(sample_ch.sample));
		end
	end

	initial begin
		#(5_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		// seed on threshold, field extremes and class edges, then two quiet lows in a row
		static logic signed [15:0] directed [24] = '{
			16'sd1500, 16'sd32767, -16'sd32768, 16'sd1199,
			16'sd1200, 16'sd1999, 16'sd2000, -16'sd1,
			16'sd500, 16'sd500, 16'sd500, 16'sd500,
			16'sd500, 16'sd500, 16'sd500, 16'sd500,
			16'sd0, 16'sd1000, 16'sd0, 16'sd1000,
			16'sd0, 16'sd1000, 16'sd0, 16'sd1000
		};
		int nblk;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: apply_config(-32768, 32767, 32767, 0, 65535, 0);
				2: apply_config(32767, -32768, -32768, 32767, 0, 64);
				3: apply_config(0, 2000, 1000, 100, 50, 8);  // crossed bounds
				4: apply_config(20000, 25000, 30000, 32767, 65535, 1);
				7: apply_config(int'($urandom_range(65535)) - 32768,
					int'($urandom_range(65535)) - 32768,
					int'($urandom_range(65535)) - 32768,
					$urandom_range(32767), $urandom_range(65535), $urandom_range(64));
				default: begin
					cfg_thr = int'($urandom_range(8000)) - 4000;
					apply_config(cfg_thr,
						clamp16(cfg_thr + int'($urandom_range(4000)) - 2000),
						clamp16(cfg_thr + int'($urandom_range(4500)) - 500),
						$urandom_range(3000), $urandom_range(1500), $urandom_range(9));
				end
			endcase
			if (ph < 3) begin
				src_idle_pct = 24;
				sink_idle_pct = 69;
			end else if (ph < 6) begin
				src_idle_pct = 69;
				sink_idle_pct = 24;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			nblk = 0;
			if (ph == 0) begin
				foreach (directed[i])
					sample_q.push_back(directed[i]);
				nblk = 3;
			end
			for (; nblk < BLOCKS_PER_PHASE; nblk++)
				gen_block();
			wait_drain();
		end

		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
